// ===== rtl/mi3_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse pipeline.
package mi3_pkg;

    // One matrix element or one inverse element.
    localparam int ELEM_W = 32;
    // Elements per matrix.
    localparam int N_ELEM = 9;
    // Packed width of a whole matrix on the streams.
    localparam int DATA_W = ELEM_W * N_ELEM;
    // Magnitude width of the determinant (|det| < 3 * 2^94).
    localparam int DET_W = 96;
    // Quotient bits resolved by the divider, one per stage.
    localparam int DIV_STEPS = 33;

    // Per-item control that travels alongside the data.
    typedef struct packed {
        logic valid;
        logic sing;
    } ctl_t;

endpackage

// ===== rtl/mi3_div.sv =====
// Nine-lane pipelined restoring divider with saturation, sharing one divisor.
module mi3_div #(
    parameter int NUM_W = 96,
    parameter int DIV_W = 96
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic [NUM_W-1:0]     num [0:8],
    input  logic [8:0]           neg,
    input  logic [DIV_W-1:0]     dmag,
    input  mi3_pkg::ctl_t        ctl_in,
    output logic [31:0]          res [0:8],
    output mi3_pkg::ctl_t        ctl_out
);
    import mi3_pkg::*;

    localparam int QB = DIV_STEPS;
    localparam int CW = DIV_W + QB + 1;
    localparam logic [QB-1:0] POS_MAX = QB'(33'h0_7FFF_FFFF);
    localparam logic [QB-1:0] NEG_MAX = QB'(33'h0_8000_0000);

    logic [NUM_W-1:0] rem_reg  [0:QB][0:8];
    logic [NUM_W-1:0] rem_next [0:QB][0:8];
    logic [QB-1:0]    q_reg    [0:QB][0:8];
    logic [QB-1:0]    q_next   [0:QB][0:8];
    logic [8:0]       ovf_reg  [0:QB];
    logic [8:0]       ovf_next [0:QB];
    logic [8:0]       neg_reg  [0:QB];
    logic [8:0]       neg_next [0:QB];
    logic [DIV_W-1:0] d_reg    [0:QB];
    logic [DIV_W-1:0] d_next   [0:QB];
    logic [QB:0]      val_reg;
    logic [QB:0]      val_next;
    logic [QB:0]      sing_reg;
    logic [QB:0]      sing_next;
    logic [31:0]      res_reg  [0:8];
    logic [31:0]      res_next [0:8];
    ctl_t             ctl_reg;

    // Entry stage flags quotients of 2^33 or more; every later stage settles one bit.
    always_comb begin
        logic [CW-1:0] dsh;
        logic [CW-1:0] rx;
        logic          ge;
        dsh = '0;
        rx  = '0;
        ge  = 1'b0;
        d_next[0]    = dmag;
        neg_next[0]  = neg;
        val_next[0]  = ctl_in.valid;
        sing_next[0] = ctl_in.sing;
        for (int l = 0; l < 9; l++) begin
            rem_next[0][l] = num[l];
            q_next[0][l]   = '0;
            ovf_next[0][l] = (CW'(num[l]) >= (CW'(dmag) << QB));
        end
        for (int k = 1; k <= QB; k++) begin
            d_next[k]    = d_reg[k-1];
            neg_next[k]  = neg_reg[k-1];
            ovf_next[k]  = ovf_reg[k-1];
            val_next[k]  = val_reg[k-1];
            sing_next[k] = sing_reg[k-1];
            dsh = CW'(d_reg[k-1]) << (QB - k);
            for (int l = 0; l < 9; l++) begin
                rx = CW'(rem_reg[k-1][l]);
                ge = (rx >= dsh);
                rem_next[k][l] = ge ? NUM_W'(rx - dsh) : rem_reg[k-1][l];
                q_next[k][l]   = q_reg[k-1][l] | (ge ? (QB'(1) << (QB - k)) : '0);
            end
        end
    end

    // Sign, saturation and the singular override on the finished quotients.
    always_comb begin
        logic [QB-1:0] q;
        q = '0;
        for (int l = 0; l < 9; l++) begin
            q = q_reg[QB][l];
            if (sing_reg[QB]) begin
                res_next[l] = '0;
            end else if (!neg_reg[QB][l]) begin
                res_next[l] = (ovf_reg[QB][l] || q > POS_MAX) ? 32'h7FFF_FFFF : q[31:0];
            end else begin
                res_next[l] = (ovf_reg[QB][l] || q > NEG_MAX) ? 32'h8000_0000
                                                              : 32'(-q[31:0]);
            end
        end
    end

    // Stage valid bits and the control of the result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
            ctl_reg <= '0;
        end else if (en) begin
            val_reg       <= val_next;
            ctl_reg.valid <= val_reg[QB];
            ctl_reg.sing  <= sing_reg[QB];
        end
    end

    // Stage payload.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg      <= rem_next;
            q_reg        <= q_next;
            ovf_reg      <= ovf_next;
            neg_reg      <= neg_next;
            d_reg        <= d_next;
            sing_reg     <= sing_next;
            res_reg      <= res_next;
        end
    end

    assign res     = res_reg;
    assign ctl_out = ctl_reg;

endmodule

// ===== rtl/matrix3x3_inverse.sv =====
// Top level of the pipelined 3x3 matrix inverse by the adjugate.
//
//  Channel | Ports                         | Contents
//  --------+-------------------------------+--------------------------------------
//  input   | s_tvalid, s_tready, s_tdata   | nine Q elements, r0c0 in lowest bits
//  result  | m_tvalid, m_tready, m_tdata,  | nine inverse elements, r0c0 lowest;
//          | m_tuser                       | tuser carries the singular flag
//
// One matrix is accepted per cycle while the skid register is empty; from acceptance to result an item passes
// six stages of cofactor and determinant arithmetic, 35 divider stages (an entry stage,
// one quotient bit per stage for nine lanes, and a result stage) and the output register.
// Reset (aresetn low at a clock edge) clears all valid bits; no item is in flight after.
// A stalled result moves into a skid register; the pipeline halts only when that is full.
module matrix3x3_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // in_r0c0, in_r0c1, in_r0c2, in_r1c0, ... in_r2c2 (32 bits each)
    input  logic [mi3_pkg::DATA_W-1:0] s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, ... inv_r2c2 (32 bits each)
    output logic [mi3_pkg::DATA_W-1:0] m_tdata,
    // singular
    output logic [0:0]                 m_tuser
);
    import mi3_pkg::*;

    localparam int NUM_W = 64 + 2 * FRAC_BITS;

    logic               en;
    logic signed [31:0] a_in [0:8];

    logic signed [63:0] pa_reg [0:8], pa_next [0:8];
    logic signed [63:0] pb_reg [0:8], pb_next [0:8];
    logic signed [31:0] e1_reg [0:2];
    logic signed [63:0] cof2_reg [0:8];
    logic signed [31:0] e2_reg [0:2];
    logic signed [64:0] plo3_reg [0:2], plo3_next [0:2];
    logic signed [63:0] phi3_reg [0:2], phi3_next [0:2];
    logic signed [63:0] cof3_reg [0:8];
    logic signed [96:0] term4_reg [0:2];
    logic signed [63:0] cof4_reg [0:8];
    logic signed [98:0] det5_reg;
    logic signed [63:0] cof5_reg [0:8];
    logic [NUM_W-1:0]   num6_reg [0:8], num6_next [0:8];
    logic [8:0]         neg6_reg, neg6_next;
    logic [DET_W-1:0]   dmag6_reg, dmag6_next;
    logic               sing6_reg;
    logic [6:1]         v_reg;
    ctl_t               ctl6;

    logic [31:0]        res_q [0:8];
    ctl_t               ctl_q;

    logic [DATA_W-1:0]  out_data_reg, skid_data_reg, res_flat;
    logic               out_sing_reg, skid_sing_reg;
    logic               out_v_reg, skid_v_reg, out_fire;

    // The whole pipeline advances unless the skid register is occupied.
    assign en       = !skid_v_reg;
    assign s_tready = en;

    // Cofactor products taken straight from the input item.
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            a_in[k] = s_tdata[k*ELEM_W +: ELEM_W];
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                pa_next[i*3+j] = a_in[((i+1)%3)*3 + (j+1)%3] * a_in[((i+2)%3)*3 + (j+2)%3];
                pb_next[i*3+j] = a_in[((i+1)%3)*3 + (j+2)%3] * a_in[((i+2)%3)*3 + (j+1)%3];
            end
        end
    end

    // Row 0 times its cofactors, split into 32-bit partial products.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            plo3_next[j] = e2_reg[j] * $signed({1'b0, cof2_reg[j][31:0]});
            phi3_next[j] = e2_reg[j] * $signed(cof2_reg[j][63:32]);
        end
    end

    // Determinant sign and magnitude, and the scaled cofactor magnitudes of the adjugate.
    always_comb begin
        logic [98:0] dabs;
        logic [63:0] cm;
        dabs       = det5_reg[98] ? 99'(-det5_reg) : 99'(det5_reg);
        dmag6_next = dabs[DET_W-1:0];
        cm         = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                cm = cof5_reg[c*3+r][63] ? 64'(-cof5_reg[c*3+r]) : 64'(cof5_reg[c*3+r]);
                num6_next[r*3+c] = NUM_W'(cm) << (2 * FRAC_BITS);
                neg6_next[r*3+c] = cof5_reg[c*3+r][63] ^ det5_reg[98];
            end
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[5:1], s_tvalid};
        end
    end

    // Front stage payload.
    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            for (int k = 0; k < 3; k++) begin
                e1_reg[k] <= a_in[k];
            end
            for (int k = 0; k < 9; k++) begin
                cof2_reg[k] <= pa_reg[k] - pb_reg[k];
            end
            e2_reg    <= e1_reg;
            plo3_reg  <= plo3_next;
            phi3_reg  <= phi3_next;
            cof3_reg  <= cof2_reg;
            for (int j = 0; j < 3; j++) begin
                term4_reg[j] <= 97'($signed({phi3_reg[j], 32'd0})) + 97'(plo3_reg[j]);
            end
            cof4_reg  <= cof3_reg;
            det5_reg  <= 99'(term4_reg[0]) + 99'(term4_reg[1]) + 99'(term4_reg[2]);
            cof5_reg  <= cof4_reg;
            num6_reg  <= num6_next;
            neg6_reg  <= neg6_next;
            dmag6_reg <= dmag6_next;
            sing6_reg <= (det5_reg == '0);
        end
    end

    assign ctl6.valid = v_reg[6];
    assign ctl6.sing  = sing6_reg;

    mi3_div #(
        .NUM_W (NUM_W),
        .DIV_W (DET_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .num     (num6_reg),
        .neg     (neg6_reg),
        .dmag    (dmag6_reg),
        .ctl_in  (ctl6),
        .res     (res_q),
        .ctl_out (ctl_q)
    );

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            res_flat[k*ELEM_W +: ELEM_W] = res_q[k];
        end
    end

    assign out_fire = out_v_reg && m_tready;

    // Output register with skid stage: control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (out_fire) begin
                skid_v_reg <= 1'b0;
            end
        end else if (ctl_q.valid) begin
            if (!out_v_reg || out_fire) begin
                out_v_reg <= 1'b1;
            end else begin
                skid_v_reg <= 1'b1;
            end
        end else if (out_fire) begin
            out_v_reg <= 1'b0;
        end
    end

    // Output register with skid stage: payload.
    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (out_fire) begin
                out_data_reg <= skid_data_reg;
                out_sing_reg <= skid_sing_reg;
            end
        end else if (ctl_q.valid) begin
            if (!out_v_reg || out_fire) begin
                out_data_reg <= res_flat;
                out_sing_reg <= ctl_q.sing;
            end else begin
                skid_data_reg <= res_flat;
                skid_sing_reg <= ctl_q.sing;
            end
        end
    end

    assign m_tvalid   = out_v_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_sing_reg;

endmodule

// ===== rtl/mi3_checker.sv =====
// Port-level assertions for the matrix inverse, bound to the top level.
module mi3_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [mi3_pkg::DATA_W-1:0] m_tdata,
    input logic [0:0]                 m_tuser
);
    // A stalled result keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A singular matrix gives an all-zero inverse.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("singular result with nonzero elements");

    // Input is held off only while a finished result is waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // No result follows a reset edge.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind matrix3x3_inverse mi3_checker u_mi3_checker (.*);
